// ===== hw/rtl/pps_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the PID position servo: field widths,
// register map, reset values, sequencer states and serial unit load ports.
// ---------------------------------------------------------------------------
package pps_pkg;

  localparam int ROTATION_DEGREES_DEFAULT = 270;

  localparam int ADC_W    = 12;
  localparam int ADC_MAX  = 4095;
  localparam int POS_W    = 24;
  localparam int GAIN_W   = 16;
  localparam int PERIOD_W = 16;
  localparam int CAL_W    = 18;
  localparam int INTEG_W  = 20;
  localparam int FRAC_W   = 16;   // period is in 1/65536 s
  localparam int DRV_SH   = 8;    // Q8.8 gains
  localparam int MA_W     = 40;   // multiplicand magnitude
  localparam int DVD_W    = 40;   // dividend magnitude
  localparam int ACC_W    = MA_W + GAIN_W + 2;
  localparam int MCNT_W   = $clog2(GAIN_W + 1);
  localparam int DCNT_W   = $clog2(DVD_W + 1);
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [POS_W-1:0]    POS_MAX        = 24'h7F_FFFF;
  localparam logic [POS_W-1:0]    POS_MIN        = 24'h80_0000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 16'd66;
  localparam logic [ADC_W-1:0]    ADC_HIGH_RESET = 12'd4095;
  localparam int                  INTEG_LIMIT    = 262144;

  typedef enum logic [2:0] {
    REG_TARGET,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_PERIOD,
    REG_ADC_LOW,
    REG_ADC_HIGH,
    REG_CAL
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_ANGLE,
    ST_ANGLE,
    ST_ERROR,
    ST_START,
    ST_DIV_DERIV,
    ST_INTEGRAL,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_DRIVE
  } state_t;

  typedef struct packed {
    logic                start;
    logic [MA_W-1:0]     a;
    logic [GAIN_W-1:0]   b;
    logic                neg;
  } mul_load_t;

  typedef struct packed {
    logic                start;
    logic [DVD_W-1:0]    dvd;
    logic [PERIOD_W-1:0] dvs;
    logic [DCNT_W-1:0]   cnt;
    logic                neg;
  } div_load_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pid_position_servo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pid_position_servo
// PID position loop on a potentiometer ADC sample, with integral clamp.
// ---------------------------------------------------------------------------
// One item (ADC sample) in gives one item out: the negated PID drive, its
// saturation flag and the measured angle. Work is done by a bit-serial
// restoring divider and a bit-serial shift-add multiplier, one bit per cycle:
// an angle division of NUM_W steps (29 at 270 degrees), a 40-step derivative
// division that overlaps the 16-step integral multiply, then three 16-step
// gain multiplies. The angle division is skipped when both ends of travel
// are equal. Items are taken one at a time; input is ready again from the
// cycle after the result is registered, even while it still waits on the
// output. Registers are written over APB at 4*index.
module pid_position_servo #(
  parameter int ROTATION_DEGREES = pps_pkg::ROTATION_DEGREES_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst,
  // s_tdata: adc_sample[11:0], zero fill [15:12]
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [15:0]                  s_tdata,
  // m_tdata: drive[23:0], position[47:24]
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [47:0]                  m_tdata,
  // m_tuser: drive_saturated[0]
  output logic                         m_tuser,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [pps_pkg::ADDR_W-1:0]   paddr,
  input  wire  [pps_pkg::DATA_W-1:0]   pwdata,
  output logic [pps_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int ADC_W   = pps_pkg::ADC_W;
  localparam int POS_W   = pps_pkg::POS_W;
  localparam int GAIN_W  = pps_pkg::GAIN_W;
  localparam int PER_W   = pps_pkg::PERIOD_W;
  localparam int CAL_W   = pps_pkg::CAL_W;
  localparam int INTEG_W = pps_pkg::INTEG_W;
  localparam int FRAC_W  = pps_pkg::FRAC_W;
  localparam int MA_W    = pps_pkg::MA_W;
  localparam int DVD_W   = pps_pkg::DVD_W;
  localparam int ACC_W   = pps_pkg::ACC_W;
  localparam int MCNT_W  = pps_pkg::MCNT_W;
  localparam int DCNT_W  = pps_pkg::DCNT_W;
  localparam int DATA_W  = pps_pkg::DATA_W;

  localparam int SCALE   = ROTATION_DEGREES * 256;
  localparam int OFFSET  = ROTATION_DEGREES * 128;
  localparam int NUM_W   = $clog2(pps_pkg::ADC_MAX * SCALE + 1);
  localparam int ANG_W   = (NUM_W + 3 > POS_W + 1) ? NUM_W + 3 : POS_W + 1;
  localparam int DIFF_W  = POS_W + 1;
  localparam int ISUM_W  = POS_W + 2;
  localparam int DER_W   = DVD_W + 1;
  localparam int SH_W    = ACC_W - pps_pkg::DRV_SH;

  localparam logic signed [ISUM_W-1:0] ISUM_MAX = ISUM_W'(pps_pkg::INTEG_LIMIT);
  localparam logic signed [ISUM_W-1:0] ISUM_MIN = -ISUM_W'(pps_pkg::INTEG_LIMIT);

  // configuration
  logic [POS_W-1:0]  target_position;
  logic [GAIN_W-1:0] gain_p;
  logic [GAIN_W-1:0] gain_i;
  logic [GAIN_W-1:0] gain_d;
  logic [PER_W-1:0]  sample_period;
  logic [ADC_W-1:0]  adc_low;
  logic [ADC_W-1:0]  adc_high;
  logic [CAL_W-1:0]  calibration_offset;

  pps_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = pps_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_position    <= '0;
      gain_p             <= '0;
      gain_i             <= '0;
      gain_d             <= '0;
      sample_period      <= pps_pkg::PERIOD_RESET;
      adc_low            <= '0;
      adc_high           <= pps_pkg::ADC_HIGH_RESET;
      calibration_offset <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pps_pkg::REG_TARGET:   target_position    <= pwdata[POS_W-1:0];
        pps_pkg::REG_GAIN_P:   gain_p             <= pwdata[GAIN_W-1:0];
        pps_pkg::REG_GAIN_I:   gain_i             <= pwdata[GAIN_W-1:0];
        pps_pkg::REG_GAIN_D:   gain_d             <= pwdata[GAIN_W-1:0];
        pps_pkg::REG_PERIOD:   sample_period      <= pwdata[PER_W-1:0];
        pps_pkg::REG_ADC_LOW:  adc_low            <= pwdata[ADC_W-1:0];
        pps_pkg::REG_ADC_HIGH: adc_high           <= pwdata[ADC_W-1:0];
        pps_pkg::REG_CAL:      calibration_offset <= pwdata[CAL_W-1:0];
        default:               ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pps_pkg::REG_TARGET:   prdata = DATA_W'(target_position);
      pps_pkg::REG_GAIN_P:   prdata = DATA_W'(gain_p);
      pps_pkg::REG_GAIN_I:   prdata = DATA_W'(gain_i);
      pps_pkg::REG_GAIN_D:   prdata = DATA_W'(gain_d);
      pps_pkg::REG_PERIOD:   prdata = DATA_W'(sample_period);
      pps_pkg::REG_ADC_LOW:  prdata = DATA_W'(adc_low);
      pps_pkg::REG_ADC_HIGH: prdata = DATA_W'(adc_high);
      pps_pkg::REG_CAL:      prdata = DATA_W'(calibration_offset);
      default:               prdata = '0;
    endcase
  end

  // bit-serial multiplier: right-shifting shift-add on magnitudes
  pps_pkg::mul_load_t  mul_ld;
  logic [MA_W-1:0]     mul_a;
  logic [MA_W:0]       mul_hi;
  logic [GAIN_W-1:0]   mul_lo;
  logic                mul_neg;
  logic [MCNT_W-1:0]   mul_cnt;
  logic [MA_W+1:0]     mul_sum;
  logic [ACC_W-1:0]    mul_mag;
  logic [ACC_W-1:0]    prod;

  assign mul_sum = {1'b0, mul_hi} + (mul_lo[0] ? {2'b00, mul_a} : '0);
  assign mul_mag = {1'b0, mul_hi, mul_lo};
  assign prod    = mul_neg ? ACC_W'(0) - mul_mag : mul_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_cnt <= '0;
    end else if (mul_ld.start) begin
      mul_a   <= mul_ld.a;
      mul_hi  <= '0;
      mul_lo  <= mul_ld.b;
      mul_neg <= mul_ld.neg;
      mul_cnt <= MCNT_W'(GAIN_W);
    end else if (mul_cnt != '0) begin
      mul_hi  <= mul_sum[MA_W+1:1];
      mul_lo  <= {mul_sum[0], mul_lo[GAIN_W-1:1]};
      mul_cnt <= mul_cnt - 1'b1;
    end
  end

  // bit-serial restoring divider on magnitudes, quotient shifts into div_dvd
  pps_pkg::div_load_t  div_ld;
  logic [DVD_W-1:0]    div_dvd;
  logic [PER_W-1:0]    div_rem;
  logic [PER_W-1:0]    div_dvs;
  logic                div_neg;
  logic [DCNT_W-1:0]   div_cnt;
  logic [PER_W:0]      div_trial;
  logic                div_fit;

  assign div_trial = {div_rem, div_dvd[DVD_W-1]};
  assign div_fit   = div_trial >= {1'b0, div_dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_ld.start) begin
      div_dvd <= div_ld.dvd;
      div_rem <= '0;
      div_dvs <= div_ld.dvs;
      div_neg <= div_ld.neg;
      div_cnt <= div_ld.cnt;
    end else if (div_cnt != '0) begin
      div_rem <= div_fit ? PER_W'(div_trial - {1'b0, div_dvs}) : PER_W'(div_trial);
      div_dvd <= {div_dvd[DVD_W-2:0], div_fit};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // sequencer state and datapath registers
  pps_pkg::state_t state, state_next;

  logic [POS_W-1:0]         position;
  logic [POS_W-1:0]         err;
  logic [POS_W-1:0]         prev_err;
  logic signed [INTEG_W-1:0] integ;
  logic [DER_W-1:0]         deriv;
  logic [ACC_W-1:0]         acc;

  // input side
  logic [ADC_W-1:0]  sample;
  logic [ADC_W:0]    adc_diff;
  logic [ADC_W:0]    adc_den;
  logic [ADC_W-1:0]  diff_mag;
  logic [ADC_W-1:0]  den_mag;
  logic [NUM_W-1:0]  num_mag;

  assign sample   = s_tdata[ADC_W-1:0];
  assign adc_diff = {1'b0, sample} - {1'b0, adc_low};
  assign adc_den  = {1'b0, adc_high} - {1'b0, adc_low};
  assign diff_mag = ADC_W'(adc_diff[ADC_W] ? -adc_diff : adc_diff);
  assign den_mag  = ADC_W'(adc_den[ADC_W] ? -adc_den : adc_den);
  assign num_mag  = NUM_W'(diff_mag * SCALE);

  // angle
  logic [ANG_W-1:0]       q_ext;
  logic [ANG_W-1:0]       angle_raw;
  logic [ANG_W-POS_W:0]   angle_top;
  logic [POS_W-1:0]       angle_sat;

  assign q_ext     = {{(ANG_W-NUM_W){1'b0}}, div_dvd[NUM_W-1:0]};
  assign angle_raw = (div_neg ? ANG_W'(0) - q_ext : q_ext) - ANG_W'(OFFSET)
                   + {{(ANG_W-CAL_W){calibration_offset[CAL_W-1]}}, calibration_offset};
  assign angle_top = angle_raw[ANG_W-1:POS_W-1];
  assign angle_sat = ((&angle_top) | ~(|angle_top)) ? angle_raw[POS_W-1:0]
                   : (angle_raw[ANG_W-1] ? pps_pkg::POS_MIN : pps_pkg::POS_MAX);

  // error and derivative setup
  logic [DIFF_W-1:0] err_raw;
  logic [POS_W-1:0]  err_sat;
  logic [DIFF_W-1:0] derr;
  logic [POS_W-1:0]  derr_mag;
  logic [POS_W-1:0]  err_mag;
  logic [PER_W-1:0]  period_eff;

  assign err_raw  = {position[POS_W-1], position}
                  - {target_position[POS_W-1], target_position};
  assign err_sat  = (err_raw[DIFF_W-1] == err_raw[DIFF_W-2]) ? err_raw[POS_W-1:0]
                  : (err_raw[DIFF_W-1] ? pps_pkg::POS_MIN : pps_pkg::POS_MAX);
  assign derr     = {err[POS_W-1], err} - {prev_err[POS_W-1], prev_err};
  assign derr_mag = POS_W'(derr[DIFF_W-1] ? -derr : derr);
  assign err_mag  = err[POS_W-1] ? -err : err;
  assign period_eff = (sample_period == '0) ? PER_W'(1) : sample_period;

  // integral and gains
  logic signed [ISUM_W-1:0]  step;
  logic signed [ISUM_W-1:0]  integ_sum;
  logic [INTEG_W-1:0]        integ_mag;
  logic [DER_W-1:0]          deriv_new;
  logic [DVD_W-1:0]          deriv_mag;
  logic [GAIN_W-1:0]         kp_mag;
  logic [GAIN_W-1:0]         ki_mag;
  logic [GAIN_W-1:0]         kd_mag;

  assign step      = $signed(prod[FRAC_W+ISUM_W-1:FRAC_W]);
  assign integ_sum = ISUM_W'(integ) + step;
  assign integ_mag = integ[INTEG_W-1] ? INTEG_W'(-integ) : INTEG_W'(integ);
  assign deriv_new = div_neg ? DER_W'(0) - {1'b0, div_dvd} : {1'b0, div_dvd};
  assign deriv_mag = DVD_W'(deriv[DER_W-1] ? -deriv : deriv);
  assign kp_mag    = gain_p[GAIN_W-1] ? -gain_p : gain_p;
  assign ki_mag    = gain_i[GAIN_W-1] ? -gain_i : gain_i;
  assign kd_mag    = gain_d[GAIN_W-1] ? -gain_d : gain_d;

  // drive
  logic [SH_W:0]          drv_raw;
  logic [SH_W-POS_W+1:0]  drv_top;
  logic                   drv_fit;
  logic [POS_W-1:0]       drv_sat;
  logic                   out_free;

  assign drv_raw  = (SH_W+1)'(0) - {acc[ACC_W-1], acc[ACC_W-1:pps_pkg::DRV_SH]};
  assign drv_top  = drv_raw[SH_W:POS_W-1];
  assign drv_fit  = (&drv_top) | ~(|drv_top);
  assign drv_sat  = drv_fit ? drv_raw[POS_W-1:0]
                  : (drv_raw[SH_W] ? pps_pkg::POS_MIN : pps_pkg::POS_MAX);
  assign out_free = ~m_tvalid | m_tready;

  assign s_tready = (state == pps_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_ld     = '0;
    div_ld     = '0;
    unique case (state)
      pps_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          div_ld.start = 1'b1;
          div_ld.dvs   = PER_W'(den_mag);
          div_ld.neg   = adc_diff[ADC_W] ^ adc_den[ADC_W];
          if (adc_den != '0) begin
            div_ld.dvd = {num_mag, {(DVD_W-NUM_W){1'b0}}};
            div_ld.cnt = DCNT_W'(NUM_W);
          end
          state_next = pps_pkg::ST_DIV_ANGLE;
        end
      end
      pps_pkg::ST_DIV_ANGLE: begin
        if (div_cnt == '0) state_next = pps_pkg::ST_ANGLE;
      end
      pps_pkg::ST_ANGLE: state_next = pps_pkg::ST_ERROR;
      pps_pkg::ST_ERROR: state_next = pps_pkg::ST_START;
      pps_pkg::ST_START: begin
        mul_ld.start = 1'b1;
        mul_ld.a     = MA_W'(err_mag);
        mul_ld.b     = period_eff;
        mul_ld.neg   = err[POS_W-1];
        div_ld.start = 1'b1;
        div_ld.dvd   = {derr_mag, {FRAC_W{1'b0}}};
        div_ld.dvs   = period_eff;
        div_ld.cnt   = DCNT_W'(DVD_W);
        div_ld.neg   = derr[DIFF_W-1];
        state_next   = pps_pkg::ST_DIV_DERIV;
      end
      pps_pkg::ST_DIV_DERIV: begin
        if (div_cnt == '0 && mul_cnt == '0) state_next = pps_pkg::ST_INTEGRAL;
      end
      pps_pkg::ST_INTEGRAL: begin
        mul_ld.start = 1'b1;
        mul_ld.a     = MA_W'(err_mag);
        mul_ld.b     = kp_mag;
        mul_ld.neg   = err[POS_W-1] ^ gain_p[GAIN_W-1];
        state_next   = pps_pkg::ST_MUL_P;
      end
      pps_pkg::ST_MUL_P: begin
        if (mul_cnt == '0) begin
          mul_ld.start = 1'b1;
          mul_ld.a     = MA_W'(integ_mag);
          mul_ld.b     = ki_mag;
          mul_ld.neg   = integ[INTEG_W-1] ^ gain_i[GAIN_W-1];
          state_next   = pps_pkg::ST_MUL_I;
        end
      end
      pps_pkg::ST_MUL_I: begin
        if (mul_cnt == '0) begin
          mul_ld.start = 1'b1;
          mul_ld.a     = deriv_mag;
          mul_ld.b     = kd_mag;
          mul_ld.neg   = deriv[DER_W-1] ^ gain_d[GAIN_W-1];
          state_next   = pps_pkg::ST_MUL_D;
        end
      end
      pps_pkg::ST_MUL_D: begin
        if (mul_cnt == '0) state_next = pps_pkg::ST_DRIVE;
      end
      pps_pkg::ST_DRIVE: begin
        if (out_free) state_next = pps_pkg::ST_IDLE;
      end
      default: state_next = pps_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      integ    <= '0;
    end else begin
      unique case (state)
        pps_pkg::ST_ANGLE: position <= angle_sat;
        pps_pkg::ST_ERROR: err      <= err_sat;
        pps_pkg::ST_START: prev_err <= err;
        pps_pkg::ST_INTEGRAL: begin
          priority if (integ_sum > ISUM_MAX) integ <= INTEG_W'(ISUM_MAX);
          else if (integ_sum < ISUM_MIN)     integ <= INTEG_W'(ISUM_MIN);
          else                               integ <= INTEG_W'(integ_sum);
          deriv <= deriv_new;
          acc   <= '0;
        end
        pps_pkg::ST_MUL_P, pps_pkg::ST_MUL_I, pps_pkg::ST_MUL_D: begin
          if (mul_cnt == '0) acc <= acc + prod;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == pps_pkg::ST_DRIVE && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {position, drv_sat};
      m_tuser  <= ~drv_fit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
